[hdl/iwr_pkg.sv]
package iwr_pkg;

  // Field widths of one input item and one result.
  localparam int unsigned MODE_W = 4;
  localparam int unsigned IDX_W  = 32;

  // Primitive modes.
  localparam logic [MODE_W-1:0] MODE_TRI         = 4'd0;
  localparam logic [MODE_W-1:0] MODE_QUAD        = 4'd1;
  localparam logic [MODE_W-1:0] MODE_TRI_STRIP   = 4'd2;
  localparam logic [MODE_W-1:0] MODE_QUAD_STRIP  = 4'd3;
  localparam logic [MODE_W-1:0] MODE_FAN         = 4'd4;
  localparam logic [MODE_W-1:0] MODE_POLYGON     = 4'd5;
  localparam logic [MODE_W-1:0] MODE_POINTS      = 4'd6;
  localparam logic [MODE_W-1:0] MODE_LINES       = 4'd7;
  localparam logic [MODE_W-1:0] MODE_LINE_STRIP  = 4'd8;
  localparam logic [MODE_W-1:0] MODE_LOOP        = 4'd9;

  // Kind of a complete group waiting in the group buffer.
  typedef enum logic [1:0] {
    GRP_TRI  = 2'd0,
    GRP_QUAD = 2'd1,
    GRP_PAIR = 2'd2
  } grp_kind_t;

  // Control handed down the row of stack cells.
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

  // Position of the last index of a group, by kind.
  function automatic logic [1:0] grp_last_pos(grp_kind_t kind);
    logic [1:0] pos;
    case (kind)
      GRP_TRI:  pos = 2'd2;
      GRP_QUAD: pos = 2'd3;
      GRP_PAIR: pos = 2'd1;
      default:  pos = 2'd1;
    endcase
    return pos;
  endfunction

  // Group buffer slot that gives the result at a given step.
  // Triangles read a,c,b, quads a,d,c,b and strip pairs b,a.
  function automatic logic [1:0] grp_sel(grp_kind_t kind, logic [1:0] step);
    logic [1:0] sel;
    case (kind)
      GRP_TRI:  sel = (step == 2'd0) ? 2'd0 : ((step == 2'd1) ? 2'd2 : 2'd1);
      GRP_QUAD: sel = (step == 2'd0) ? 2'd0 : 2'(3'd4 - {1'b0, step});
      GRP_PAIR: sel = (step == 2'd0) ? 2'd1 : 2'd0;
      default:  sel = 2'd0;
    endcase
    return sel;
  endfunction

endpackage

[hdl/iwr_in_if.sv]
interface iwr_in_if;
  logic                          valid;
  logic                          ready;
  logic [iwr_pkg::MODE_W-1:0]    mode;
  logic [iwr_pkg::IDX_W-1:0]     index;
  logic                          last_in;

  modport source (output valid, mode, index, last_in, input ready);
  modport sink (input valid, mode, index, last_in, output ready);
endinterface

[hdl/iwr_out_if.sv]
interface iwr_out_if;
  logic                          valid;
  logic                          ready;
  logic [iwr_pkg::IDX_W-1:0]     index_out;
  logic                          last_out;
  logic                          overflow;

  modport source (output valid, index_out, last_out, overflow, input ready);
  modport sink (input valid, index_out, last_out, overflow, output ready);
endinterface

[hdl/iwr_cell.sv]
module iwr_cell (
  input  logic                      clk,
  input  iwr_pkg::stk_ctl_t         ctl,
  input  logic [iwr_pkg::IDX_W-1:0] from_prev,
  input  logic [iwr_pkg::IDX_W-1:0] from_next,
  output logic [iwr_pkg::IDX_W-1:0] value
);

  // A push moves the entry one place deeper, a pop one place toward the top.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      value <= from_prev;
    end else if (ctl.pop) begin
      value <= from_next;
    end
  end

endmodule

[hdl/iwr_stack.sv]
module iwr_stack #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                      clk,
  input  iwr_pkg::stk_ctl_t         ctl,
  input  logic [iwr_pkg::IDX_W-1:0] push_data,
  output logic [iwr_pkg::IDX_W-1:0] top
);

  logic [iwr_pkg::IDX_W-1:0] cell_value [DEPTH];

  // Row of cells: the newest index sits in the first cell.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [iwr_pkg::IDX_W-1:0] prev_value;
    logic [iwr_pkg::IDX_W-1:0] next_value;

    if (i == 0) begin : g_first
      assign prev_value = push_data;
    end else begin : g_inner_prev
      assign prev_value = cell_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign next_value = cell_value[i];
    end else begin : g_inner_next
      assign next_value = cell_value[i+1];
    end

    iwr_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .from_prev (prev_value),
      .from_next (next_value),
      .value     (cell_value[i])
    );
  end

  assign top = cell_value[0];

endmodule

[hdl/index_winding_reverser.sv]
// Index winding reverser.
// The items channel carries one vertex index per transaction, with the list's
// mode (read on its first index) and a last mark on the final index. The
// results channel returns the indices in reversed winding order, with a last
// mark on a list's final result if its last index ends a group or a stored
// list, and an overflow flag on reversed results of a list that overflowed.
// An index is taken while no results are being sequenced and the output
// register is free. Grouped modes (triangles, quads and strips) then emit the
// results of the completed group and take no index until they are out. Fan,
// polygon, point and line modes store indices in a row of MAX_LIST stack
// cells and, after the last index, pop one index per cycle unless the
// receiver stalls; the single output register sets the rate.
// A fan's first index is loaded into the output register at the edge that
// takes it. The first result of a group or of a drained list is loaded from
// the group or drain state, which the index that completes it enters.
// Synchronous reset empties the stack, clears the list state and drops the
// output register. When the receiver stalls, the current result holds in the
// output register and no further transaction is taken or emitted.
module index_winding_reverser #(
  parameter int unsigned MAX_LIST = 64
) (
  input  logic      clk,
  input  logic      rst,
  iwr_in_if.sink    items,
  iwr_out_if.source results
);

  localparam int unsigned CW = $clog2(MAX_LIST + 1);

  typedef enum logic [2:0] {
    S_IN    = 3'b001,
    S_GROUP = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t                          state;
  logic                            list_started;
  logic [iwr_pkg::MODE_W-1:0]      list_mode;
  logic [1:0]                      gpos;
  logic [CW-1:0]                   count;
  logic                            ovf_seen;
  iwr_pkg::grp_kind_t              grp_kind;
  logic [1:0]                      step;
  logic                            last_pending;
  logic [iwr_pkg::IDX_W-1:0]       grp_buf [4];

  logic                            out_valid;
  logic [iwr_pkg::IDX_W-1:0]       out_index;
  logic                            out_last;
  logic                            out_ovf;

  logic                            slot_free;
  logic                            accept;
  logic                            is_first;
  logic [iwr_pkg::MODE_W-1:0]      eff_mode;
  logic                            grouped;
  logic                            stored_mode;
  iwr_pkg::grp_kind_t              in_kind;
  logic                            grp_done;
  logic                            fan_head;
  logic                            do_push;
  logic                            full;
  logic                            drain_pop;
  logic [iwr_pkg::IDX_W-1:0]       stack_top;
  iwr_pkg::stk_ctl_t               stk_ctl;
  logic [1:0]                      sel;

  // Input decode: the mode comes from the first index of each list.
  always_comb begin
    slot_free   = !out_valid || results.ready;
    accept      = items.valid && items.ready;
    is_first    = !list_started;
    eff_mode    = is_first ? items.mode : list_mode;
    grouped     = (eff_mode <= iwr_pkg::MODE_QUAD_STRIP);
    stored_mode = (eff_mode >= iwr_pkg::MODE_FAN) && (eff_mode <= iwr_pkg::MODE_LOOP);
    if (eff_mode == iwr_pkg::MODE_TRI) begin
      in_kind = iwr_pkg::GRP_TRI;
    end else if (eff_mode == iwr_pkg::MODE_QUAD) begin
      in_kind = iwr_pkg::GRP_QUAD;
    end else begin
      in_kind = iwr_pkg::GRP_PAIR;
    end
    grp_done    = grouped && (gpos == iwr_pkg::grp_last_pos(in_kind));
    fan_head    = (eff_mode == iwr_pkg::MODE_FAN) && is_first;
    full        = (count == CW'(MAX_LIST));
    do_push     = accept && stored_mode && !fan_head && !full;
    drain_pop   = (state == S_DRAIN) && slot_free;
    stk_ctl.push = do_push;
    stk_ctl.pop  = drain_pop;
    sel         = iwr_pkg::grp_sel(grp_kind, step);
  end

  assign items.ready = (state == S_IN) && slot_free;

  iwr_stack #(
    .DEPTH (MAX_LIST)
  ) u_stack (
    .clk       (clk),
    .ctl       (stk_ctl),
    .push_data (items.index),
    .top       (stack_top)
  );

  // Group buffer holds the indices of the group being collected.
  always_ff @(posedge clk) begin
    if (accept && grouped) begin
      grp_buf[gpos] <= items.index;
    end
  end

  // List control and sequencing of results.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IN;
      list_started <= 1'b0;
      list_mode    <= '0;
      gpos         <= '0;
      count        <= '0;
      ovf_seen     <= 1'b0;
      grp_kind     <= iwr_pkg::GRP_TRI;
      step         <= '0;
      last_pending <= 1'b0;
    end else begin
      case (state)
        S_IN: begin
          if (accept) begin
            list_started <= !items.last_in;
            if (is_first) begin
              list_mode <= items.mode;
            end
            if (grouped) begin
              if (grp_done) begin
                gpos         <= '0;
                grp_kind     <= in_kind;
                step         <= '0;
                last_pending <= items.last_in;
                state        <= S_GROUP;
              end else if (items.last_in) begin
                gpos <= '0;
              end else begin
                gpos <= gpos + 2'd1;
              end
            end
            if (do_push) begin
              count <= count + CW'(1);
            end
            if (stored_mode && !fan_head && full) begin
              ovf_seen <= 1'b1;
            end
            // A fan whose only index is its head has nothing to drain.
            if (items.last_in && stored_mode && !(fan_head && count == '0)) begin
              state <= S_DRAIN;
            end
          end
        end
        S_GROUP: begin
          if (slot_free) begin
            step <= step + 2'd1;
            if (step == iwr_pkg::grp_last_pos(grp_kind)) begin
              state <= S_IN;
            end
          end
        end
        S_DRAIN: begin
          if (slot_free) begin
            count <= count - CW'(1);
            if (count == CW'(1)) begin
              ovf_seen <= 1'b0;
              state    <= S_IN;
            end
          end
        end
        default: begin
          state <= S_IN;
        end
      endcase
    end
  end

  // Output register: loaded by a fan head, a group step or a stack pop.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= (accept && fan_head) || (state == S_GROUP) || (state == S_DRAIN);
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (state == S_GROUP) begin
        out_index <= grp_buf[sel];
        out_last  <= last_pending && (step == iwr_pkg::grp_last_pos(grp_kind));
        out_ovf   <= 1'b0;
      end else if (state == S_DRAIN) begin
        out_index <= stack_top;
        out_last  <= (count == CW'(1));
        out_ovf   <= ovf_seen;
      end else begin
        out_index <= items.index;
        out_last  <= items.last_in;
        out_ovf   <= 1'b0;
      end
    end
  end

  assign results.valid     = out_valid;
  assign results.index_out = out_index;
  assign results.last_out  = out_last;
  assign results.overflow  = out_ovf;

  // The stack never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_LIST))
    else $error("stack count beyond capacity");

  // Draining only happens with something stored.
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |-> (count != '0))
    else $error("drain with empty stack");

  // The final pop leaves the list state clean for the next list.
  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    (drain_pop && count == CW'(1)) |=> (count == '0 && !ovf_seen && state == S_IN))
    else $error("list state not cleared after drain");

endmodule

[bench/index_winding_reverser_tb.sv]
module index_winding_reverser_tb;

  localparam int unsigned LIST_DEPTH = 64;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_ITEMS = 370;
  localparam int unsigned STEADY_ITEMS = 310;
  localparam int unsigned DRAIN_CYCLES = 50;

  typedef logic [iwr_pkg::MODE_W-1:0] mode_t;

  // Modes above the loop mode are undefined and must produce nothing.
  localparam mode_t MODE_UNDEF_LOW = iwr_pkg::MODE_LOOP + 4'd1;
  localparam mode_t MODE_UNDEF_TOP = 4'd15;

  typedef struct packed {
    logic [iwr_pkg::MODE_W-1:0] mode;
    logic [iwr_pkg::IDX_W-1:0]  index;
    logic                       last;
  } vertex_item_t;

  typedef struct packed {
    logic [iwr_pkg::IDX_W-1:0] index_out;
    logic                      last_out;
    logic                      overflow;
  } vertex_result_t;

  logic clk;
  logic rst;

  iwr_in_if  items ();
  iwr_out_if results ();

  index_winding_reverser #(.MAX_LIST(LIST_DEPTH)) dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items.sink),
    .results (results.source)
  );

  // Stimulus and expectation stores.
  vertex_item_t   pending_vertices[$];
  vertex_result_t expected_vertices[$];

  // Shadow of the list state inside the block.
  logic [iwr_pkg::IDX_W-1:0]  group_buf [4];
  logic [iwr_pkg::IDX_W-1:0]  list_store [LIST_DEPTH];
  logic [iwr_pkg::MODE_W-1:0] list_mode;
  int unsigned                group_pos;
  int unsigned                stored_cnt;
  bit                         list_open;
  bit                         list_overflow;

  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned in_accepts;
  int unsigned drv_seen;
  int unsigned hold_id;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned queued_items;
  bit          steady;

  // Clock generation.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic vertex_result_t make_result(logic [iwr_pkg::IDX_W-1:0] idx, logic ovf);
    vertex_result_t r;
    r.index_out = idx;
    r.last_out  = 1'b0;
    r.overflow  = ovf;
    return r;
  endfunction

  // Compute the reordered indices that one accepted transaction releases.
  task automatic predict_winding(input logic [iwr_pkg::MODE_W-1:0] m,
                                 input logic [iwr_pkg::IDX_W-1:0] idx,
                                 input logic fin);
    int unsigned    need;
    bit             first;
    vertex_result_t batch[$];
    first = 1'b0;
    need  = 0;
    if (!list_open) begin
      list_mode     = m;
      list_open     = 1'b1;
      group_pos     = 0;
      stored_cnt    = 0;
      list_overflow = 1'b0;
      first         = 1'b1;
    end

    if (list_mode == iwr_pkg::MODE_TRI) need = 3;
    else if (list_mode == iwr_pkg::MODE_QUAD) need = 4;
    else if (list_mode == iwr_pkg::MODE_TRI_STRIP ||
             list_mode == iwr_pkg::MODE_QUAD_STRIP) need = 2;

    if (need != 0) begin
      // Grouped modes release a group as soon as it is complete.
      group_buf[group_pos] = idx;
      if (group_pos + 1 >= need) begin
        if (need == 3) begin
          batch.insert(batch.size(), make_result(group_buf[0], 1'b0));
          batch.insert(batch.size(), make_result(group_buf[2], 1'b0));
          batch.insert(batch.size(), make_result(group_buf[1], 1'b0));
        end else if (need == 4) begin
          batch.insert(batch.size(), make_result(group_buf[0], 1'b0));
          batch.insert(batch.size(), make_result(group_buf[3], 1'b0));
          batch.insert(batch.size(), make_result(group_buf[2], 1'b0));
          batch.insert(batch.size(), make_result(group_buf[1], 1'b0));
        end else begin
          batch.insert(batch.size(), make_result(group_buf[1], 1'b0));
          batch.insert(batch.size(), make_result(group_buf[0], 1'b0));
        end
        group_pos = 0;
      end else begin
        group_pos = (group_pos + 1) & 3;
      end
    end else if (list_mode == iwr_pkg::MODE_FAN && first) begin
      batch.insert(batch.size(), make_result(idx, 1'b0));
    end else if (list_mode >= iwr_pkg::MODE_FAN && list_mode <= iwr_pkg::MODE_LOOP) begin
      // Reversing modes store the index, or note that the store is full.
      if (stored_cnt < LIST_DEPTH) begin
        list_store[stored_cnt] = idx;
        stored_cnt++;
      end else begin
        list_overflow = 1'b1;
      end
    end

    if (fin) begin
      if (list_mode >= iwr_pkg::MODE_FAN && list_mode <= iwr_pkg::MODE_LOOP) begin
        for (int k = int'(stored_cnt) - 1; k >= 0; k--) begin
          batch.insert(batch.size(), make_result(list_store[k], list_overflow));
        end
      end
      if (batch.size() > 0) batch[batch.size() - 1].last_out = 1'b1;
      list_open     = 1'b0;
      group_pos     = 0;
      stored_cnt    = 0;
      list_overflow = 1'b0;
    end

    foreach (batch[i]) expected_vertices.insert(expected_vertices.size(), batch[i]);
  endtask

  task automatic add_item(input logic [iwr_pkg::MODE_W-1:0] m,
                          input logic [iwr_pkg::IDX_W-1:0] idx,
                          input logic fin);
    vertex_item_t it;
    it.mode  = m;
    it.index = idx;
    it.last  = fin;
    pending_vertices.insert(pending_vertices.size(), it);
    queued_items++;
  endtask

  // Queue one list with random content; later indices sometimes carry a stray mode.
  task automatic add_list(input logic [iwr_pkg::MODE_W-1:0] m, input int unsigned len);
    logic [iwr_pkg::MODE_W-1:0] mf;
    logic [iwr_pkg::IDX_W-1:0]  idx;
    for (int unsigned i = 0; i < len; i++) begin
      mf = (i != 0 && $urandom_range(7) == 0) ? mode_t'($urandom) : m;
      case ($urandom_range(15))
        0:       idx = '0;
        1:       idx = '1;
        default: idx = $urandom;
      endcase
      add_item(mf, idx, i == len - 1);
    end
  endtask

  // Pick a mode and a length; grouped modes mostly get whole groups.
  task automatic add_random_list();
    logic [iwr_pkg::MODE_W-1:0] m;
    int unsigned                len;
    int unsigned                r;
    m = ($urandom_range(99) < 10) ? mode_t'($urandom_range(MODE_UNDEF_TOP, MODE_UNDEF_LOW))
                                  : mode_t'($urandom_range(iwr_pkg::MODE_LOOP,
                                                           iwr_pkg::MODE_TRI));
    r = $urandom_range(99);
    if (r < 85) len = $urandom_range(12, 1);
    else if (r < 95) len = $urandom_range(40, 13);
    else len = $urandom_range(70, 60);
    if ($urandom_range(99) < 80) begin
      if (m == iwr_pkg::MODE_TRI) len = 3 * $urandom_range(4, 1);
      else if (m == iwr_pkg::MODE_QUAD) len = 4 * $urandom_range(3, 1);
      else if (m == iwr_pkg::MODE_TRI_STRIP || m == iwr_pkg::MODE_QUAD_STRIP)
        len = 2 * $urandom_range(6, 1);
    end
    add_list(m, len);
  endtask

  // Wait until every queued transaction is taken and every result has come.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_vertices.size() != 0 || items.valid || expected_vertices.size() != 0);
  endtask

  // Run-length guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Input side: predict every accepted transaction.
  always @(posedge clk) begin
    if (!rst && items.valid && items.ready) begin
      predict_winding(items.mode, items.index, items.last_in);
      in_accepts++;
    end
  end

  // Output side: compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    vertex_result_t exp_r;
    if (!rst && results.valid && results.ready) begin
      if (expected_vertices.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual index %h last %b ovf %b",
                 $time, results.index_out, results.last_out, results.overflow);
        mismatches++;
      end else begin
        exp_r = expected_vertices.pop_front();
        if (results.index_out !== exp_r.index_out) begin
          $display("%0t: index_out mismatch, expected %h, actual %h",
                   $time, exp_r.index_out, results.index_out);
          mismatches++;
        end
        if (results.last_out !== exp_r.last_out) begin
          $display("%0t: last_out mismatch, expected %b, actual %b",
                   $time, exp_r.last_out, results.last_out);
          mismatches++;
        end
        if (results.overflow !== exp_r.overflow) begin
          $display("%0t: overflow mismatch, expected %b, actual %b",
                   $time, exp_r.overflow, results.overflow);
          mismatches++;
        end
      end
    end
  end

  // Driver: hold a transaction until it is taken, then offer the next or idle.
  always @(negedge clk) begin
    vertex_item_t cur;
    bit           busy;
    busy     = items.valid && (in_accepts == drv_seen);
    drv_seen = in_accepts;
    if (rst) begin
      items.valid <= 1'b0;
    end else if (!busy) begin
      if (pending_vertices.size() != 0 && (steady || $urandom_range(99) >= 33)) begin
        cur = pending_vertices.pop_front();
        items.valid   <= 1'b1;
        items.mode    <= cur.mode;
        items.index   <= cur.index;
        items.last_in <= cur.last;
      end else begin
        items.valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_id != hold_seen) begin
      hold_seen = hold_id;
      hold_left = HOLD_CYCLES;
    end
    if (rst) begin
      results.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      results.ready <= 1'b0;
    end else begin
      results.ready <= steady || ($urandom_range(99) >= 33);
    end
  end

  initial begin
    items.valid   = 1'b0;
    items.mode    = iwr_pkg::MODE_TRI;
    items.index   = '0;
    items.last_in = 1'b0;
    results.ready = 1'b0;
    rst           = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed lists: every mode, extreme indices and the corner cases.
    add_item(iwr_pkg::MODE_TRI, '0, 1'b0);
    add_item(iwr_pkg::MODE_TRI, '1, 1'b0);
    add_item(iwr_pkg::MODE_TRI, 32'h0000_0005, 1'b1);
    add_item(iwr_pkg::MODE_QUAD, 32'h0000_0001, 1'b0);
    add_item(iwr_pkg::MODE_QUAD, 32'h0000_0002, 1'b0);
    add_item(iwr_pkg::MODE_QUAD, 32'h0000_0003, 1'b0);
    add_item(iwr_pkg::MODE_QUAD, 32'h0000_0004, 1'b1);
    // A trailing half pair is dropped, so no result carries the last mark.
    add_item(iwr_pkg::MODE_TRI_STRIP, 32'h0000_000A, 1'b0);
    add_item(iwr_pkg::MODE_TRI_STRIP, 32'h0000_000B, 1'b0);
    add_item(iwr_pkg::MODE_TRI_STRIP, 32'h0000_000C, 1'b1);
    add_item(iwr_pkg::MODE_QUAD_STRIP, 32'hFFFF_0000, 1'b0);
    add_item(iwr_pkg::MODE_QUAD_STRIP, 32'h0000_FFFF, 1'b1);
    add_item(iwr_pkg::MODE_FAN, '1, 1'b0);
    add_item(iwr_pkg::MODE_FAN, '0, 1'b0);
    add_item(iwr_pkg::MODE_FAN, 32'h0000_0007, 1'b1);
    add_item(iwr_pkg::MODE_POLYGON, 32'h8000_0000, 1'b0);
    add_item(iwr_pkg::MODE_POLYGON, 32'h7FFF_FFFF, 1'b1);
    add_item(iwr_pkg::MODE_POINTS, 32'h1234_5678, 1'b1);
    // A mode change inside a list is ignored.
    add_item(iwr_pkg::MODE_LINES, 32'h0000_0010, 1'b0);
    add_item(iwr_pkg::MODE_TRI, 32'h0000_0011, 1'b1);
    add_item(iwr_pkg::MODE_LINE_STRIP, 32'hDEAD_BEEF, 1'b0);
    add_item(iwr_pkg::MODE_LINE_STRIP, 32'hCAFE_F00D, 1'b1);
    add_item(iwr_pkg::MODE_LOOP, 32'h0000_0020, 1'b1);
    add_item(MODE_UNDEF_TOP, 32'h0000_0030, 1'b0);
    add_item(MODE_UNDEF_TOP, 32'h0000_0031, 1'b1);
    // An incomplete triangle yields nothing.
    add_item(iwr_pkg::MODE_TRI, 32'h0000_0040, 1'b0);
    add_item(iwr_pkg::MODE_TRI, 32'h0000_0041, 1'b1);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering, then store overflow.
    hold_id++;
    add_list(iwr_pkg::MODE_TRI, 30);
    add_list(iwr_pkg::MODE_POLYGON, 70);
    add_list(iwr_pkg::MODE_FAN, 66);
    add_list(iwr_pkg::MODE_POINTS, LIST_DEPTH);
    wait_drained();

    // Stretch with no idling on either side.
    steady = 1'b1;
    while (queued_items < STEADY_ITEMS) add_random_list();
    wait_drained();
    steady = 1'b0;

    // Random lists with random idling.
    while (queued_items < RANDOM_ITEMS) add_random_list();
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
